// ===== hw/rtl/tccw_pkg.sv =====
// Shared types and constants for the text console cursor writer.
// No dependencies; imported by every module of the block.
package tccw_pkg;

	localparam int ADDR_W    = 11;
	localparam int CHAR_W    = 8;
	localparam int COL_OUT_W = 7;
	localparam int ROW_OUT_W = 5;
	// beat count per item, enough for the largest tab width
	localparam int CNT_W     = 4;

	localparam logic CMD_PRINT     = 1'b0;
	localparam logic CMD_BACKSPACE = 1'b1;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

	// one classified input item, as handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0]     n_wr;
		logic                 clr;
		logic [ADDR_W-1:0]    addr;
		logic [CHAR_W-1:0]    ch;
		logic [COL_OUT_W-1:0] col;
		logic [ROW_OUT_W-1:0] row;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== hw/rtl/tccw_front.sv =====
// Front end: accepts input transfers, tracks the cursor and classifies each item.
// Depends on tccw_pkg.
module tccw_front #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     cmd,
	input  logic [tccw_pkg::CHAR_W-1:0] char_code,
	input  tccw_pkg::q_status_t      q_status,
	output logic                     in_ready,
	output logic                     push,
	output tccw_pkg::entry_t         push_data
);
	import tccw_pkg::*;

	localparam int CW  = $clog2(COLUMNS);
	localparam int RW  = $clog2(ROWS);
	localparam int PW  = CW + RW + 1;
	localparam int AFW = (PW > ADDR_W) ? PW : ADDR_W;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_n, wr_col;
	logic [RW-1:0]    row_n, wr_row;
	logic [CW:0]      col_ext;
	logic [RW:0]      row_ext;
	logic [CNT_W-1:0] n_wr;
	logic             clr;
	logic [CHAR_W-1:0] wr_ch;
	logic [AFW-1:0]   addr_full;
	logic             accept;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		col_ext = {1'b0, col_q};
		row_ext = {1'b0, row_q};
		wr_col  = col_q;
		wr_row  = row_q;
		wr_ch   = char_code;
		n_wr    = '0;
		clr     = 1'b0;
		col_n   = col_q;
		row_n   = row_q;
		if (cmd == CMD_BACKSPACE) begin
			if (col_q != '0) begin
				col_n = col_q - 1'b1;
			end else if (row_q != '0) begin
				col_n = CW'(COLUMNS - 1);
				row_n = row_q - 1'b1;
			end
			wr_col = col_n;
			wr_row = row_n;
			wr_ch  = CH_SPACE;
			n_wr   = CNT_W'(1);
		end else begin
			case (char_code)
				CH_TAB: begin
					col_ext = col_ext + (CW+1)'(TAB_WIDTH);
					wr_ch   = CH_SPACE;
					n_wr    = CNT_W'(TAB_WIDTH);
				end
				CH_NEWLINE: begin
					row_ext = row_ext + 1'b1;
					col_ext = '0;
				end
				default: begin
					col_ext = col_ext + 1'b1;
					n_wr    = CNT_W'(1);
				end
			endcase
			if (col_ext >= (CW+1)'(COLUMNS)) begin
				row_ext = row_ext + 1'b1;
				col_ext = '0;
			end
			if (row_ext >= (RW+1)'(ROWS)) begin
				clr     = 1'b1;
				row_ext = '0;
				col_ext = '0;
			end
			col_n = col_ext[CW-1:0];
			row_n = row_ext[RW-1:0];
		end
	end

	// characters and tabs write at the row held before any wrap; a backspace writes at the cell it moves back to
	assign addr_full = AFW'(wr_row) * AFW'(COLUMNS) + AFW'(wr_col);

	always_comb begin
		push_data.n_wr = n_wr;
		push_data.clr  = clr;
		push_data.addr = addr_full[ADDR_W-1:0];
		push_data.ch   = wr_ch;
		push_data.col  = COL_OUT_W'(col_n);
		push_data.row  = ROW_OUT_W'(row_n);
	end

	// a newline that stays on screen yields no transfer
	assign push = accept && ((n_wr != '0) || clr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

endmodule

// ===== hw/rtl/tccw_fifo.sv =====
// Two-entry queue between the front end and the back end.
// Depends on tccw_pkg.
module tccw_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tccw_pkg::entry_t    push_data,
	input  logic                pop,
	output tccw_pkg::entry_t    pop_data,
	output tccw_pkg::q_status_t status
);
	import tccw_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== hw/rtl/tccw_back.sv =====
// Back end: expands each queued item into cell-write and clear transfers.
// Depends on tccw_pkg.
module tccw_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tccw_pkg::entry_t        q_data,
	input  tccw_pkg::q_status_t     q_status,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_action,
	output logic                    out_last,
	output logic [tccw_pkg::ADDR_W-1:0] out_addr,
	output logic [tccw_pkg::CHAR_W-1:0] out_char,
	output logic [tccw_pkg::COL_OUT_W-1:0] out_col,
	output logic [tccw_pkg::ROW_OUT_W-1:0] out_row
);
	import tccw_pkg::*;

	entry_t           cur_q;
	logic             cur_valid_q;
	logic [CNT_W-1:0] k_q;
	logic             is_wr, beat;

	assign is_wr      = (k_q < cur_q.n_wr);
	assign out_valid  = cur_valid_q;
	assign out_action = is_wr ? ACT_WRITE : ACT_CLEAR;
	assign out_addr   = is_wr ? (cur_q.addr + ADDR_W'(k_q)) : '0;
	assign out_char   = is_wr ? cur_q.ch : CH_SPACE;
	assign out_last   = is_wr ? ((k_q + 1'b1 == cur_q.n_wr) && !cur_q.clr) : 1'b1;
	assign out_col    = cur_q.col;
	assign out_row    = cur_q.row;

	assign beat = out_valid && out_ready;
	assign pop  = (!cur_valid_q || (beat && out_last)) && !q_status.empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (beat && !out_last) begin
			k_q <= k_q + 1'b1;
		end else if (!cur_valid_q || beat) begin
			cur_valid_q <= pop;
			k_q         <= '0;
		end
	end

endmodule

// ===== hw/rtl/text_console_cursor_writer.sv =====
// Text console cursor writer, top level: front end, queue and back end.
// Depends on tccw_pkg, tccw_front, tccw_fifo and tccw_back.
//
// Input channel s_*: one transfer per character (tuser = 0) or backspace
// (tuser = 1). Output channel m_*: one transfer per cell write (tuser = 0)
// or clear-screen command (tuser = 1); tlast marks the final transfer of an
// input item, and every transfer carries the cursor position after the item.
// A printable character or backspace gives one transfer, a tab TAB_WIDTH,
// a newline none, and moving past the bottom row adds one clear.
// Throughput: the back end sends one transfer per cycle while m_tready is
// high, and an input item gives 0 to TAB_WIDTH+1 output transfers; the front
// end takes one input per cycle while the two-entry queue has room.
// Input to output: with the queue empty and the back end idle, an input
// item is written into the queue, then loaded into the back end's
// current-item register, and m_tvalid rises with that load.
// Reset puts the cursor at the origin and empties the queue. A stalled
// receiver holds the current output transfer; the queue then fills and
// s_tready drops until room frees up.
module text_console_cursor_writer #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [10:0] cell_address, [18:11] cell_char,
	                               // [25:19] cursor_col, [30:26] cursor_row, [31] zero
	output logic        m_tuser,   // [0] action
	output logic        m_tlast    // last_of_run
);
	import tccw_pkg::*;

	q_status_t            q_status;
	entry_t               push_data, pop_data;
	logic                 push, pop;
	logic [ADDR_W-1:0]    out_addr;
	logic [CHAR_W-1:0]    out_char;
	logic [COL_OUT_W-1:0] out_col;
	logic [ROW_OUT_W-1:0] out_row;

	tccw_front #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.cmd       (s_tuser),
		.char_code (s_tdata),
		.q_status  (q_status),
		.in_ready  (s_tready),
		.push      (push),
		.push_data (push_data)
	);

	tccw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	tccw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (pop_data),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_action (m_tuser),
		.out_last   (m_tlast),
		.out_addr   (out_addr),
		.out_char   (out_char),
		.out_col    (out_col),
		.out_row    (out_row)
	);

	assign m_tdata = {1'b0, out_row, out_col, out_char, out_addr};

endmodule
